@@ sv/serial_command_pwm_bridge_drive_macros.svh @@
// Assertion macros shared by the drive bridge checkers.
`ifndef SERIAL_COMMAND_PWM_BRIDGE_DRIVE_MACROS_SVH
`define SERIAL_COMMAND_PWM_BRIDGE_DRIVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/scpb_pkg.sv @@
// Shared constants, types and helpers of the serial command PWM bridge drive.
package scpb_pkg;

  localparam int FRAME_DEPTH_DEF = 128;
  localparam int AXIS_COUNT_DEF  = 6;

  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] SPEED_STEP = 8'd5;

  localparam logic [7:0] PWM_PERIOD_RST  = 8'd50;
  localparam logic [7:0] START_CODE_RST  = 8'd66;
  localparam logic [7:0] END_CODE_RST    = 8'd69;
  localparam logic [7:0] CLAMP_ABOVE_RST = 8'd44;
  localparam logic [7:0] CLAMP_TO_RST    = 8'd48;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ABOVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_TO    = 3'd4;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [7:0] speed;
    logic       left_dir;
    logic       right_dir;
  } decode_t;

  // ASCII digit to speed, wrapping at 8 bits
  function automatic logic [7:0] digit_speed(input logic [7:0] b);
    logic [7:0] d;
    d = b - DIGIT_ZERO;
    return d * SPEED_STEP;
  endfunction

endpackage

@@ sv/serial_command_pwm_bridge_drive.sv @@
// Top level: command byte framing and PWM drive of a group of H-bridges.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per event: opcode 0
//   is a received serial byte on rx_byte, opcode 1 is one PWM counter tick.
//   Output channel (out_valid/out_ready) returns exactly one beat per input
//   beat: the forward, reverse and enable pin levels of every axis after
//   the event, plus frame_accepted when the byte was the end code.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   pwm_period, start_code, end_code, clamp_above and clamp_to; it is
//   always ready and should be used only while no beat is in flight.
//   The result is registered and shows from the edge that takes its beat.
//   Throughput is one beat per cycle while the receiver keeps up, set by
//   the single result register; a new beat is taken while the held result
//   drains. When the receiver stalls, the result register holds and
//   in_ready drops only while that register is full and out_ready is low.
//   Reset clears the frame, stops all bridges, drops out_valid and restores
//   the default register values; the pin outputs themselves are not reset.
module serial_command_pwm_bridge_drive #(
  parameter int FRAME_DEPTH = scpb_pkg::FRAME_DEPTH_DEF,
  parameter int AXIS_COUNT  = scpb_pkg::AXIS_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [AXIS_COUNT-1:0]            drive_forward,
  output logic [AXIS_COUNT-1:0]            drive_reverse,
  output logic [AXIS_COUNT-1:0]            bridge_enable,
  output logic                             frame_accepted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int IDX_W = $clog2(FRAME_DEPTH);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(FRAME_DEPTH - 1);
  localparam logic [AXIS_COUNT-1:0] ALL_MASK  = '1;
  // left group is the lower half of the axes
  localparam logic [AXIS_COUNT-1:0] LEFT_MASK = AXIS_COUNT'((1 << (AXIS_COUNT / 2)) - 1);

  // configuration registers
  logic [7:0] pwm_period, start_code, end_code, clamp_above, clamp_to;

  // frame and drive state
  logic [IDX_W-1:0]      byte_index, byte_index_next;
  logic [3:0][7:0]       frame_bytes, frame_bytes_next, frame_base;
  logic [7:0]            speed, speed_next;
  logic                  left_direction, left_direction_next;
  logic                  right_direction, right_direction_next;
  logic                  start_pending, start_pending_next;
  logic                  running, running_next;
  logic [7:0]            pwm_count, pwm_count_next;
  logic [AXIS_COUNT-1:0] held_fwd, held_fwd_next;
  logic [AXIS_COUNT-1:0] held_rev, held_rev_next;
  logic [AXIS_COUNT-1:0] held_ena, held_ena_next;
  logic                  accepted_next;

  logic                  accept_in;
  logic [IDX_W-1:0]      idx_start;
  logic [AXIS_COUNT-1:0] dir_mask;
  scpb_pkg::decode_t     decoded;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept_in = in_valid && in_ready;

  // a frame index of zero means the stored bytes are stale
  assign frame_base = (byte_index == '0) ? '0 : frame_bytes;
  assign idx_start  = (rx_byte == start_code) ? '0 : byte_index;
  assign dir_mask   = (left_direction ? LEFT_MASK : '0) |
                      (right_direction ? ~LEFT_MASK : '0);

  scpb_frame_decode u_decode (
    .frame       (frame_base),
    .clamp_above (clamp_above),
    .clamp_to    (clamp_to),
    .result      (decoded)
  );

  always_comb begin
    byte_index_next      = byte_index;
    frame_bytes_next     = frame_bytes;
    speed_next           = speed;
    left_direction_next  = left_direction;
    right_direction_next = right_direction;
    start_pending_next   = start_pending;
    running_next         = running;
    pwm_count_next       = pwm_count;
    held_fwd_next        = held_fwd;
    held_rev_next        = held_rev;
    held_ena_next        = held_ena;
    accepted_next        = 1'b0;
    if (accept_in) begin
      if (opcode == scpb_pkg::OP_BYTE) begin
        frame_bytes_next = frame_base;
        if (rx_byte != end_code) begin
          // keep payload bytes one to four, saturate the index
          for (int k = 0; k < 4; k++) begin
            if (idx_start == IDX_W'(k + 1)) begin
              frame_bytes_next[k] = rx_byte;
            end
          end
          byte_index_next = (idx_start < IDX_MAX) ? idx_start + 1'b1 : idx_start;
        end else begin
          byte_index_next      = '0;
          speed_next           = decoded.speed;
          left_direction_next  = decoded.left_dir;
          right_direction_next = decoded.right_dir;
          start_pending_next   = 1'b1;
          accepted_next        = 1'b1;
        end
      end else begin
        held_fwd_next = '0;
        held_rev_next = '0;
        if (start_pending) begin
          held_ena_next      = ALL_MASK;
          running_next       = 1'b1;
          start_pending_next = 1'b0;
        end
        if (running || start_pending) begin
          if (speed == '0) begin
            // zero speed stops everything in this tick
            running_next  = 1'b0;
            held_ena_next = '0;
          end else if (pwm_count < speed) begin
            held_fwd_next = dir_mask;
            held_rev_next = ~dir_mask;
          end
        end
        pwm_count_next = (pwm_count >= pwm_period) ? '0 : pwm_count + 8'd1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period  <= scpb_pkg::PWM_PERIOD_RST;
      start_code  <= scpb_pkg::START_CODE_RST;
      end_code    <= scpb_pkg::END_CODE_RST;
      clamp_above <= scpb_pkg::CLAMP_ABOVE_RST;
      clamp_to    <= scpb_pkg::CLAMP_TO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scpb_pkg::CFG_PWM_PERIOD:  pwm_period  <= cfg_data;
        scpb_pkg::CFG_START_CODE:  start_code  <= cfg_data;
        scpb_pkg::CFG_END_CODE:    end_code    <= cfg_data;
        scpb_pkg::CFG_CLAMP_ABOVE: clamp_above <= cfg_data;
        scpb_pkg::CFG_CLAMP_TO:    clamp_to    <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame and drive state: advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      frame_bytes     <= '0;
      speed           <= '0;
      left_direction  <= 1'b0;
      right_direction <= 1'b0;
      start_pending   <= 1'b0;
      running         <= 1'b0;
      pwm_count       <= '0;
      held_fwd        <= '0;
      held_rev        <= '0;
      held_ena        <= '0;
    end else begin
      byte_index      <= byte_index_next;
      frame_bytes     <= frame_bytes_next;
      speed           <= speed_next;
      left_direction  <= left_direction_next;
      right_direction <= right_direction_next;
      start_pending   <= start_pending_next;
      running         <= running_next;
      pwm_count       <= pwm_count_next;
      held_fwd        <= held_fwd_next;
      held_rev        <= held_rev_next;
      held_ena        <= held_ena_next;
    end
  end

  // result register: load on accept, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      drive_forward  <= held_fwd_next;
      drive_reverse  <= held_rev_next;
      bridge_enable  <= held_ena_next;
      frame_accepted <= accepted_next;
    end
  end

endmodule

@@ sv/scpb_frame_decode.sv @@
// Frame decode: speed, turn detection, clamp and group directions.
module scpb_frame_decode (
  input  logic [3:0][7:0]      frame,
  input  logic [7:0]           clamp_above,
  input  logic [7:0]           clamp_to,
  output scpb_pkg::decode_t    result
);

  logic       turn;
  logic [7:0] raw_speed;
  logic       dir_flag;
  logic       turn_flag;

  assign dir_flag  = (frame[0] != scpb_pkg::DIGIT_ZERO);
  assign turn_flag = (frame[2] != scpb_pkg::DIGIT_ZERO);
  assign turn      = (frame[1] < frame[3]);
  assign raw_speed = turn ? scpb_pkg::digit_speed(frame[3])
                          : scpb_pkg::digit_speed(frame[1]);

  always_comb begin
    result.speed = (raw_speed > clamp_above) ? clamp_to : raw_speed;
    if (turn) begin
      // opposite groups spin against each other
      result.left_dir  = !turn_flag;
      result.right_dir = turn_flag;
    end else begin
      result.left_dir  = dir_flag;
      result.right_dir = dir_flag;
    end
  end

endmodule

@@ sv/scpb_port_checker.sv @@
// Port-level checker for the drive bridge, bound to the top level.
`include "serial_command_pwm_bridge_drive_macros.svh"

module scpb_port_checker #(
  parameter int AXIS_COUNT = scpb_pkg::AXIS_COUNT_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [AXIS_COUNT-1:0] drive_forward,
  input logic [AXIS_COUNT-1:0] drive_reverse,
  input logic [AXIS_COUNT-1:0] bridge_enable,
  input logic                  frame_accepted
);

  `SCPB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(drive_forward) && $stable(drive_reverse) && $stable(bridge_enable) && $stable(frame_accepted), "result beat changed while stalled")

  `SCPB_ASSERT_NOW(a_no_shoot_through, clk, rst, out_valid, (drive_forward & drive_reverse) == '0, "forward and reverse pins high together")

  `SCPB_ASSERT_NOW(a_drive_needs_enable, clk, rst, out_valid, ((drive_forward | drive_reverse) & ~bridge_enable) == '0, "drive pin high on a disabled bridge")

  `SCPB_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled with an empty result register")

  // every accepted input beat shows up as a result on the next cycle
  `SCPB_ASSERT_NEXT(a_result_next, clk, rst, in_valid && in_ready, out_valid, "accepted beat left no result")

endmodule

bind serial_command_pwm_bridge_drive scpb_port_checker #(
  .AXIS_COUNT (AXIS_COUNT)
) u_port_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .drive_forward  (drive_forward),
  .drive_reverse  (drive_reverse),
  .bridge_enable  (bridge_enable),
  .frame_accepted (frame_accepted)
);

@@ bench/bridge_drive_sb_pkg.sv @@
// Scoreboard class with the drive predictor for the serial command PWM bridge bench.
package bridge_drive_sb_pkg;

  import scpb_pkg::*;

  localparam int AXES = AXIS_COUNT_DEF;
  typedef logic [AXES-1:0] axis_bits_t;

  typedef struct packed {
    axis_bits_t fwd;
    axis_bits_t rev;
    axis_bits_t en;
    logic       accepted;
  } pin_levels_t;

  class bridge_drive_scoreboard;
    // register copies
    logic [7:0] period_top, start_byte, end_byte, clamp_limit, clamp_value;
    // predicted block state
    logic [6:0] frame_pos;
    logic [7:0] frame_data [4];
    logic [7:0] duty;
    logic       left_fwd, right_fwd, arm_pending, active;
    logic [7:0] pwm_ctr;
    axis_bits_t pin_fwd, pin_rev, pin_en;

    pin_levels_t expected_levels[$];
    int errors, checked;
    int n_bytes, n_ticks, n_frames, n_turns, n_clamped, n_stops, n_pulsing, n_saturated;

    function new();
      period_top  = PWM_PERIOD_RST;
      start_byte  = START_CODE_RST;
      end_byte    = END_CODE_RST;
      clamp_limit = CLAMP_ABOVE_RST;
      clamp_value = CLAMP_TO_RST;
      frame_pos   = '0;
      frame_data  = '{default: '0};
      duty        = '0;
      left_fwd    = 1'b0;
      right_fwd   = 1'b0;
      arm_pending = 1'b0;
      active      = 1'b0;
      pwm_ctr     = '0;
      pin_fwd     = '0;
      pin_rev     = '0;
      pin_en      = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_PWM_PERIOD:  period_top  = val;
        CFG_START_CODE:  start_byte  = val;
        CFG_END_CODE:    end_byte    = val;
        CFG_CLAMP_ABOVE: clamp_limit = val;
        CFG_CLAMP_TO:    clamp_value = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void decode_frame();
      logic [7:0] s;
      logic       dir;
      dir = (frame_data[0] != DIGIT_ZERO);
      s = (frame_data[1] - DIGIT_ZERO) * SPEED_STEP;
      left_fwd  = dir;
      right_fwd = dir;
      // byte 4 above byte 2 means a turn: groups run opposite ways
      if (frame_data[1] < frame_data[3]) begin
        s = (frame_data[3] - DIGIT_ZERO) * SPEED_STEP;
        n_turns++;
        if (frame_data[2] != DIGIT_ZERO) begin
          left_fwd  = 1'b0;
          right_fwd = 1'b1;
        end else begin
          left_fwd  = 1'b1;
          right_fwd = 1'b0;
        end
      end
      if (s > clamp_limit) begin
        s = clamp_value;
        n_clamped++;
      end
      duty = s;
      arm_pending = 1'b1;
      n_frames++;
    endfunction

    function logic take_byte(logic [7:0] b);
      if (frame_pos == 0) frame_data = '{default: '0};
      if (b == start_byte) frame_pos = '0;
      if (b != end_byte) begin
        if (frame_pos >= 1 && frame_pos <= 4) frame_data[int'(frame_pos) - 1] = b;
        if (int'(frame_pos) < FRAME_DEPTH_DEF - 1) frame_pos++;
        else n_saturated++;
        return 1'b0;
      end
      frame_pos = '0;
      decode_frame();
      return 1'b1;
    endfunction

    function void pwm_tick();
      axis_bits_t left_grp, dirmask, f, r, e;
      left_grp = axis_bits_t'((1 << (AXES / 2)) - 1);
      f = '0;
      r = '0;
      e = pin_en;
      if (arm_pending) begin
        e = '1;
        active = 1'b1;
        arm_pending = 1'b0;
      end
      if (active) begin
        dirmask = (left_fwd ? left_grp : '0) | (right_fwd ? ~left_grp : '0);
        if (pwm_ctr < duty) begin
          f = dirmask;
          r = ~dirmask;
          n_pulsing++;
        end
        if (duty == 0) begin
          active = 1'b0;
          e = '0;
          f = '0;
          r = '0;
          n_stops++;
        end
      end
      pin_fwd = f;
      pin_rev = r;
      pin_en  = e;
      if (pwm_ctr >= period_top) pwm_ctr = '0;
      else pwm_ctr = pwm_ctr + 8'd1;
    endfunction

    function void note_event(logic op, logic [7:0] b);
      pin_levels_t lv;
      lv.accepted = 1'b0;
      if (op == OP_BYTE) begin
        lv.accepted = take_byte(b);
        n_bytes++;
      end else begin
        pwm_tick();
        n_ticks++;
      end
      lv.fwd = pin_fwd;
      lv.rev = pin_rev;
      lv.en  = pin_en;
      expected_levels.push_back(lv);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] drive check: %s", $time, msg);
    endtask

    task check_levels(axis_bits_t fwd, axis_bits_t rev, axis_bits_t en, logic acc);
      pin_levels_t w;
      if (expected_levels.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      w = expected_levels.pop_front();
      checked++;
      if (fwd !== w.fwd) report($sformatf("drive_forward got %h want %h", fwd, w.fwd));
      if (rev !== w.rev) report($sformatf("drive_reverse got %h want %h", rev, w.rev));
      if (en !== w.en) report($sformatf("bridge_enable got %h want %h", en, w.en));
      if (acc !== w.accepted)
        report($sformatf("frame_accepted got %b want %b", acc, w.accepted));
    endtask
  endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level bench: drives command bytes and PWM ticks into the bridge drive and scores results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scpb_pkg::*;
  import bridge_drive_sb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic opcode;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  axis_bits_t drive_forward;
  axis_bits_t drive_reverse;
  axis_bits_t bridge_enable;
  logic frame_accepted;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  bridge_drive_scoreboard sb;

  // idling switches for sender and receiver; hold_req asks for one long receiver stall
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int stall_cycles = 0;
  int cycles = 0;

  serial_command_pwm_bridge_drive uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_forward  (drive_forward),
    .drive_reverse  (drive_reverse),
    .bridge_enable  (bridge_enable),
    .frame_accepted (frame_accepted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: drop ready at random, or hold it low for a long stretch on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = !rst && (!rx_idle_on || $urandom_range(99) >= 16);
    end
  end

  // Score every result beat at the edge where it is taken; count input stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_levels(drive_forward, drive_reverse, bridge_enable, frame_accepted);
    if (!rst && in_valid && !in_ready) stall_cycles++;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one beat; hold valid and payload until taken. Called and returns at a falling edge.
  task automatic send_event(input logic op, input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.note_event(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(OP_BYTE, b);
  endtask

  // tick payload byte is don't-care; randomize it anyway
  task automatic send_tick();
    send_event(OP_TICK, 8'($urandom_range(255)));
  endtask

  // Lead byte, four frame bytes, end code. With start equal to end, lead with another byte.
  task automatic send_frame(input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3, input logic [7:0] b4);
    logic [7:0] lead;
    lead = (sb.start_byte != sb.end_byte) ? sb.start_byte : sb.start_byte + 8'd1;
    send_byte(lead);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
    send_byte(b4);
    send_byte(sb.end_byte);
  endtask

  function automatic logic [7:0] digit(input int n);
    return DIGIT_ZERO + 8'(n);
  endfunction

  // mostly ASCII digits, '0' often, now and then any byte
  function automatic logic [7:0] pick_digit();
    int r;
    r = $urandom_range(99);
    if (r < 20) return DIGIT_ZERO;
    if (r < 85) return digit($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  // Drop valid, then wait until every expected result has drained.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all five registers back to back, then drop the write channel.
  task automatic write_settings(input logic [7:0] period, input logic [7:0] start_c,
                                input logic [7:0] end_c, input logic [7:0] above,
                                input logic [7:0] clamp_val);
    logic [7:0] vals [5];
    logic [CFG_IDX_W-1:0] regs [5];
    vals = '{period, start_c, end_c, above, clamp_val};
    regs = '{CFG_PWM_PERIOD, CFG_START_CODE, CFG_END_CODE, CFG_CLAMP_ABOVE, CFG_CLAMP_TO};
    for (int i = 0; i < 5; i++) begin
      cfg_valid = 1'b1;
      cfg_index = regs[i];
      cfg_data = vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Random traffic until the item count reaches target: mostly well-formed frames
  // followed by tick runs, plus noise, broken frames, stops and at most one overlong frame.
  task automatic run_random(input int target);
    int r;
    int n;
    bit long_done;
    logic [7:0] b;
    long_done = 1'b0;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame(pick_digit(), pick_digit(),
                   ($urandom_range(1) ? DIGIT_ZERO : pick_digit()), pick_digit());
        n = $urandom_range(1, 40);
        repeat (n) send_tick();
      end else if (r < 72) begin
        n = $urandom_range(1, 80);
        repeat (n) send_tick();
      end else if (r < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(255)));
      end else if (r < 93) begin
        // broken frame: start, a few bytes, maybe a restart, no end
        send_byte(sb.start_byte);
        n = $urandom_range(1, 3);
        repeat (n) send_byte(pick_digit());
        if ($urandom_range(1)) send_byte(sb.start_byte);
        send_tick();
      end else if (r < 97 || long_done) begin
        // zero speed: byte 4 not above byte 2, so the bridges stop
        send_frame(pick_digit(), DIGIT_ZERO, 8'($urandom_range(255)), DIGIT_ZERO);
        n = $urandom_range(1, 4);
        repeat (n) send_tick();
      end else begin
        // overlong frame drives the index into saturation
        long_done = 1'b1;
        send_byte(sb.start_byte);
        repeat (130) begin
          do b = 8'($urandom_range(255)); while (b == sb.end_byte);
          send_byte(b);
        end
        send_byte(sb.end_byte);
        repeat (3) send_tick();
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_BYTE;
    rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_PWM_PERIOD;
    cfg_data = 8'h00;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: reset defaults. Tick before any frame, a plain forward frame,
    // a clamped turn, a turn the other way, then a zero-speed stop.
    send_tick();
    send_frame(digit(1), digit(5), digit(0), digit(3));
    send_tick();
    send_tick();
    send_frame(digit(0), digit(2), digit(0), digit(9));
    send_tick();
    send_frame(digit(7), digit(3), digit(1), digit(8));
    send_tick();
    send_frame(digit(1), digit(0), digit(0), digit(0));
    send_tick();
    run_random(300);

    // Longest period, extreme codes, clamp never fires. Apply back-pressure midway.
    wait_drained();
    write_settings(8'd255, 8'd0, 8'd255, 8'd255, 8'd0);
    run_random(items_sent + 60);
    hold_req = 1'b1;
    run_random(550);

    // Shortest nonzero period, start equal to end, every nonzero speed clamped to full.
    // No idling on either side here.
    wait_drained();
    write_settings(8'd1, 8'h58, 8'h58, 8'd0, 8'd255);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_byte(sb.start_byte);
    send_tick();
    send_tick();
    run_random(800);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Period zero holds the counter; codes swapped to the other extremes.
    wait_drained();
    write_settings(8'd0, 8'd255, 8'd0, 8'd100, 8'd7);
    send_frame(digit(1), digit(9), digit(0), digit(0));
    repeat (3) send_tick();
    run_random(1050);

    // Random settings.
    wait_drained();
    write_settings(8'($urandom_range(1, 30)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    run_random(1300);

    // Back to default codes and clamp, short period.
    wait_drained();
    write_settings(8'd12, START_CODE_RST, END_CODE_RST, CLAMP_ABOVE_RST, CLAMP_TO_RST);
    run_random(1550);

    wait_drained();
    repeat (8) @(negedge clk);

    $display("run covered %0d bytes and %0d ticks: %0d frames (%0d turns, %0d clamped)",
             sb.n_bytes, sb.n_ticks, sb.n_frames, sb.n_turns, sb.n_clamped);
    $display("%0d pulsing ticks, %0d stops, %0d index saturations, %0d stall cycles, %0d checked",
             sb.n_pulsing, sb.n_stops, sb.n_saturated, stall_cycles, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
